@@ design/dhf_pkg.sv @@
package dhf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = ADDR_W + 1;
    localparam int ROW_W      = 12;
    localparam int PADDR_W    = 4;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_ROW_WIDTH     = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [1:0] REG_INVALID_VALUE = 2'd2;
    localparam logic [1:0] REG_INVERSE_MODE  = 2'd3;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    typedef struct packed {
        logic [COL_W-1:0] width;   // already clamped to [3, MAX_WIDTH]
        logic [ROW_W-1:0] count;   // already clamped to >= 3
        t_pix             thr;
        logic             inv;
    } t_cfg;

    typedef struct packed {
        t_pix              pixel;
        logic              drain;
        logic [ADDR_W-1:0] col;
        logic              complete;
        logic              last;
        logic              fill;
    } t_cmd;

    typedef struct packed {
        t_pix pixel;
        logic eor;
        logic eof;
    } t_result;

endpackage

@@ design/dhf_ram.sv @@
module dhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dhf_front.sv @@
module dhf_front import dhf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pixel,
    input  logic i_drain,
    output logic o_full,
    input  t_cfg i_cfg,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    logic [ADDR_W-1:0] r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    t_cmd              r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    logic              accept;
    logic              take;
    logic              complete;
    logic              last;
    t_cmd              cmd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign accept      = i_push && !o_full;
    assign take        = i_cmd_take && o_cmd_valid;

    assign complete = ({1'b0, r_in_col} + COL_W'(1)) >= i_cfg.width;
    assign last     = r_in_row >= (i_cfg.count - ROW_W'(1));

    always_comb begin
        cmd.pixel    = i_pixel;
        cmd.drain    = i_drain;
        cmd.col      = r_in_col;
        cmd.complete = !i_drain && complete;
        cmd.last     = last;
        cmd.fill     = (r_in_row != '0) && !last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (accept) begin
                r_q[r_wp] <= cmd;
                r_wp      <= !r_wp;
                if (!i_drain) begin
                    if (complete) begin
                        r_in_col <= '0;
                        r_in_row <= last ? '0 : r_in_row + ROW_W'(1);
                    end else begin
                        r_in_col <= r_in_col + ADDR_W'(1);
                    end
                end
            end
            if (take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, take};
        end
    end

endmodule

@@ design/dhf_back.sv @@
module dhf_back import dhf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    typedef enum logic [2:0] {S_IDLE, S_EMIT, S_WR, S_RD, S_EV, S_FILL} t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic              r_sel;        // which RAM collects the incoming row
    logic              r_out_pend;
    logic [ADDR_W-1:0] r_out_col;
    logic              r_out_last;
    logic              r_out_inval;
    logic [COL_W-1:0]  r_j;
    logic              r_inrun;
    logic [COL_W-1:0]  r_start;
    t_pix              r_left;
    t_pix              r_prev;
    logic [COL_W-1:0]  r_t;
    logic [ADDR_W-1:0] r_k;
    t_pix              r_dd;
    t_result           r_oq [2];
    logic              r_owp;
    logic              r_orp;
    logic [1:0]        r_ocnt;

    t_pix              rd0, rd1, rd_in, rd_out;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_pix              wdata;
    logic [ADDR_W-1:0] ra_in;

    t_pix              border;
    logic              at_end;
    t_pix              v;
    logic              bad;
    logic              run_end;
    logic [COL_W-1:0]  ev_start;
    t_pix              ev_left;
    t_pix              ev_right;
    logic [COL_W-1:0]  ev_t;
    logic [COL_W-1:0]  run_len;
    logic [COL_W+2:0]  len5;
    logic              too_long;
    t_pix              dd;
    logic              push;
    logic              pop;
    logic              eor;
    t_result           res;

    assign ra_in  = r_j[ADDR_W-1:0];
    assign rd_in  = r_sel ? rd1 : rd0;
    assign rd_out = r_sel ? rd0 : rd1;

    dhf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we && !r_sel),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_sel ? r_out_col : ra_in),
        .o_rdata (rd0)
    );

    dhf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we && r_sel),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_sel ? ra_in : r_out_col),
        .o_rdata (rd1)
    );

    // scan classification
    assign border  = i_cfg.inv ? '0 : '1;
    assign at_end  = (r_j == '0) || (r_j == i_cfg.width - COL_W'(1));
    assign v       = at_end ? border : rd_in;
    assign bad     = i_cfg.inv ? (v == i_cfg.thr) : (v <= i_cfg.thr);

    always_comb begin
        ev_start = r_inrun ? r_start : r_j;
        ev_left  = r_inrun ? r_left : ((r_j == '0) ? border : r_prev);
        run_end  = 1'b0;
        ev_t     = r_j;
        ev_right = v;
        if (bad) begin
            if (r_j == i_cfg.width - COL_W'(1)) begin
                run_end  = 1'b1;
                ev_t     = i_cfg.width;
                ev_right = border;
            end
        end else if (r_inrun) begin
            run_end = 1'b1;
        end
    end

    assign run_len  = ev_t - ev_start;
    assign len5     = {run_len, 2'b00} + {2'b00, run_len};
    assign too_long = i_cfg.inv ? (len5 > {1'b0, i_cfg.width, 2'b00})
                                : ({run_len, 1'b0} > {1'b0, i_cfg.width});
    assign dd = i_cfg.inv ? ((ev_left > ev_right) ? ev_left : ev_right)
                          : ((ev_left < ev_right) ? ev_left : ev_right);

    always_comb begin
        we    = 1'b0;
        waddr = r_k;
        wdata = r_dd;
        case (r_state)
            S_WR: begin
                we    = !r_cmd.drain;
                waddr = r_cmd.col;
                wdata = r_cmd.pixel;
            end
            S_EV: begin
                we    = !bad && at_end;
                waddr = ra_in;
                wdata = border;
            end
            S_FILL: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // output side
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid
                        && (!r_out_pend || (r_ocnt != 2'd2));
    assign eor  = ({1'b0, r_out_col} + COL_W'(1)) >= i_cfg.width;
    assign push = (r_state == S_EMIT);
    assign pop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    always_comb begin
        res.pixel = r_out_inval ? i_cfg.thr : rd_out;
        res.eor   = eor;
        res.eof   = eor && r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_out_pend  <= 1'b0;
            r_out_col   <= '0;
            r_out_last  <= 1'b0;
            r_out_inval <= 1'b0;
            r_inrun     <= 1'b0;
            r_owp       <= 1'b0;
            r_orp       <= 1'b0;
            r_ocnt      <= '0;
        end else begin
            if (push) begin
                r_oq[r_owp] <= res;
                r_owp       <= !r_owp;
            end
            if (pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, push} - {1'b0, pop};

            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd   <= i_cmd;
                        r_state <= r_out_pend ? S_EMIT : S_WR;
                    end
                end
                S_EMIT: begin
                    if (eor) begin
                        r_out_pend <= 1'b0;
                        r_out_col  <= '0;
                    end else begin
                        r_out_col <= r_out_col + ADDR_W'(1);
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_j     <= '0;
                    r_inrun <= 1'b0;
                    if (r_cmd.drain || !r_cmd.complete) begin
                        r_state <= S_IDLE;
                    end else if (r_cmd.fill) begin
                        r_state <= S_RD;
                    end else begin
                        r_sel       <= !r_sel;
                        r_out_pend  <= 1'b1;
                        r_out_col   <= '0;
                        r_out_last  <= r_cmd.last;
                        r_out_inval <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (!bad) begin
                        r_prev <= v;
                    end
                    if (run_end) begin
                        r_inrun <= 1'b0;
                        if (too_long) begin
                            r_sel       <= !r_sel;
                            r_out_pend  <= 1'b1;
                            r_out_col   <= '0;
                            r_out_last  <= r_cmd.last;
                            r_out_inval <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_dd    <= dd;
                            r_k     <= ev_start[ADDR_W-1:0];
                            r_t     <= ev_t;
                            r_state <= S_FILL;
                        end
                    end else begin
                        if (bad && !r_inrun) begin
                            r_inrun <= 1'b1;
                            r_start <= r_j;
                            r_left  <= ev_left;
                        end
                        if (r_j + COL_W'(1) >= i_cfg.width) begin
                            r_sel       <= !r_sel;
                            r_out_pend  <= 1'b1;
                            r_out_col   <= '0;
                            r_out_last  <= r_cmd.last;
                            r_out_inval <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_j     <= r_j + COL_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_FILL: begin
                    if ({1'b0, r_k} + COL_W'(1) == r_t) begin
                        if (r_t + COL_W'(1) >= i_cfg.width) begin
                            r_sel       <= !r_sel;
                            r_out_pend  <= 1'b1;
                            r_out_col   <= '0;
                            r_out_last  <= r_cmd.last;
                            r_out_inval <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_j     <= r_t + COL_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_k <= r_k + ADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/disparity_hole_fill_scanline.sv @@
// Scanline disparity hole fill, output one row late.
// Input channel (push/full): one transaction per pixel in raster order, or a
// drain transaction (i_drain=1) that carries no pixel and only pushes out one
// pending output pixel. Result channel (empty/pop): filled pixels of the
// previous row with end-of-row and end-of-frame marks.
// A two-entry command queue decouples the input side from the processing
// engine, and a two-entry result queue decouples the engine from the reader,
// so a stalled reader only blocks input once both queues are full.
// Each transaction goes through the write state, after an emit state when it
// also emits a pixel. The transaction that completes an interior row starts a
// fill pass over the row buffer: a read and an evaluate state per pixel scanned
// plus a fill state per pixel rewritten inside a hole, in turn on the single
// read and write port of the row RAM. First and last rows of a frame are
// swapped in at once. Two row RAMs ping-pong: one collects the incoming row
// while the other is read out. Each later transaction releases one pixel,
// which goes through the command queue and the emit state to the result queue.
// Reset (synchronous, active low) clears counters and queues; config returns
// to width 640, 480 rows, invalid value 16, normal mode. Row RAM contents are
// not cleared. Write configuration only while the block is idle.
module disparity_hole_fill_scanline import dhf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_pixel,
    input  logic               i_drain,
    // result channel
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_filled_pixel,
    output logic               o_end_of_row,
    output logic               o_end_of_frame,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [10:0] r_row_width;
    logic [11:0] r_row_count;
    logic [7:0]  r_invalid_value;
    logic        r_inverse_mode;

    logic        cfg_wr;
    logic [1:0]  reg_idx;
    t_cfg        cfg;
    logic        cmd_valid;
    t_cmd        cmd;
    logic        cmd_take;
    t_result     res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width     <= 11'd640;
            r_row_count     <= 12'd480;
            r_invalid_value <= 8'd16;
            r_inverse_mode  <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ROW_WIDTH:     r_row_width     <= pwdata[10:0];
                REG_ROW_COUNT:     r_row_count     <= pwdata[11:0];
                REG_INVALID_VALUE: r_invalid_value <= pwdata[7:0];
                REG_INVERSE_MODE:  r_inverse_mode  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_WIDTH:     prdata = {21'd0, r_row_width};
            REG_ROW_COUNT:     prdata = {20'd0, r_row_count};
            REG_INVALID_VALUE: prdata = {24'd0, r_invalid_value};
            REG_INVERSE_MODE:  prdata = {31'd0, r_inverse_mode};
            default:           prdata = '0;
        endcase
    end

    // width saturates to [3, MAX_WIDTH], row count to at least 3
    always_comb begin
        if (r_row_width < COL_W'(3)) begin
            cfg.width = COL_W'(3);
        end else if (r_row_width > COL_W'(MAX_WIDTH)) begin
            cfg.width = COL_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_row_width;
        end
        cfg.count = (r_row_count < ROW_W'(3)) ? ROW_W'(3) : r_row_count;
        cfg.thr   = r_invalid_value;
        cfg.inv   = r_inverse_mode;
    end

    dhf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .i_drain     (i_drain),
        .o_full      (full),
        .i_cfg       (cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    dhf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_filled_pixel = res.pixel;
    assign o_end_of_row   = res.eor;
    assign o_end_of_frame = res.eof;

endmodule
